// File: hw/rtl/snte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snte_pkg
// Shared types and constants for the number token encoder.
// ----------------------------------------------------------------------------
package snte_pkg;

   // Input modes
   localparam logic [1:0] SNTE_MODE_INT = 2'd0;
   localparam logic [1:0] SNTE_MODE_F32 = 2'd1;
   localparam logic [1:0] SNTE_MODE_F64 = 2'd2;

   // Token header bytes
   localparam logic [7:0] SNTE_HDR_INT32 = 8'h24;
   localparam logic [7:0] SNTE_HDR_INT64 = 8'h25;
   localparam logic [7:0] SNTE_HDR_F32   = 8'h28;
   localparam logic [7:0] SNTE_HDR_F64   = 8'h29;

   // Small integer prefix, varint end mark
   localparam logic [7:0] SNTE_SMALL_PFX = 8'hc0;
   localparam logic [1:0] SNTE_VAR_END   = 2'b10;

   // Seven-bit groups ahead of the final byte: at most nine
   localparam int SNTE_GRP_MAX = 9;
   localparam int SNTE_GRP_BITS = 7;
   localparam int SNTE_BODY_W = SNTE_GRP_MAX * SNTE_GRP_BITS;
   localparam int SNTE_GRP_W = 4;

   // Fixed group counts for the float modes (groups before the final byte)
   localparam logic [SNTE_GRP_W-1:0] SNTE_F32_GRPS = 4'd4;
   localparam logic [SNTE_GRP_W-1:0] SNTE_F64_GRPS = 4'd9;

   localparam int SNTE_QUEUE_DEPTH = 2;

   // One classified token, ready to serialize
   typedef struct packed {
      logic                   has_hdr;
      logic [7:0]             hdr;
      logic [SNTE_BODY_W-1:0] body;
      logic [SNTE_GRP_W-1:0]  ngrp;
      logic [7:0]             tail;
   } snte_desc_type;

endpackage
`default_nettype wire

// File: hw/rtl/snte_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snte_front
// Classifies one number into a token descriptor (header, groups, tail).
// ----------------------------------------------------------------------------
module snte_front (
   input  wire logic [1:0]             req_mode,
   input  wire logic [63:0]            req_value,
   output snte_pkg::snte_desc_type     desc,
   output logic                        desc_ok
);
   import snte_pkg::*;

   logic                   neg;
   logic [63:0]            zz;
   logic                   is_small;
   logic                   is_32;
   logic [SNTE_BODY_W-1:0] rest;
   logic [SNTE_GRP_W-1:0]  var_grps;

   assign neg      = req_value[63];
   assign zz       = {req_value[62:0], 1'b0} ^ {64{neg}};
   assign is_small = (req_value[63:4] == {60{neg}});
   assign is_32    = (req_value[63:31] == {33{neg}});
   // when the value fits 32 bits, the upper zigzag half is zero already
   assign rest     = {{(SNTE_BODY_W - 58){1'b0}}, zz[63:6]};

   // number of seven-bit groups above the low six bits, up to the highest nonzero one
   always_comb begin
      var_grps = '0;
      for (int i = 0; i < SNTE_GRP_MAX; i++) begin
         if (rest[i*SNTE_GRP_BITS +: SNTE_GRP_BITS] != '0) begin
            var_grps = SNTE_GRP_W'(i + 1);
         end
      end
   end

   always_comb begin
      desc    = '0;
      desc_ok = 1'b1;
      case (req_mode)
         SNTE_MODE_INT: begin
            if (is_small) begin
               desc.has_hdr = 1'b0;
               desc.ngrp    = '0;
               desc.tail    = SNTE_SMALL_PFX | {3'b000, zz[4:0]};
            end else begin
               desc.has_hdr = 1'b1;
               desc.hdr     = is_32 ? SNTE_HDR_INT32 : SNTE_HDR_INT64;
               desc.body    = rest;
               desc.ngrp    = var_grps;
               desc.tail    = {SNTE_VAR_END, zz[5:0]};
            end
         end
         SNTE_MODE_F32: begin
            desc.has_hdr = 1'b1;
            desc.hdr     = SNTE_HDR_F32;
            desc.body    = {{(SNTE_BODY_W - 25){1'b0}}, req_value[31:7]};
            desc.ngrp    = SNTE_F32_GRPS;
            desc.tail    = {1'b0, req_value[6:0]};
         end
         SNTE_MODE_F64: begin
            desc.has_hdr = 1'b1;
            desc.hdr     = SNTE_HDR_F64;
            desc.body    = {{(SNTE_BODY_W - 57){1'b0}}, req_value[63:7]};
            desc.ngrp    = SNTE_F64_GRPS;
            desc.tail    = {1'b0, req_value[6:0]};
         end
         default: begin
            desc_ok = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: hw/rtl/snte_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snte_queue
// Small descriptor queue between classifier and serializer.
// ----------------------------------------------------------------------------
module snte_queue #(
   parameter int DEPTH = snte_pkg::SNTE_QUEUE_DEPTH
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire snte_pkg::snte_desc_type push_desc,
   output logic                         full,
   output logic                         q_valid,
   output snte_pkg::snte_desc_type      q_desc,
   input  wire logic                    pop
);
   import snte_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   snte_desc_type     slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_desc  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count over depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid)
      else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/snte_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snte_back
// Serializer: header (if any), seven-bit groups high to low, then the final byte.
// ----------------------------------------------------------------------------
module snte_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    q_valid,
   input  wire snte_pkg::snte_desc_type q_desc,
   output logic                         pop,
   output logic                         rsp_valid,
   output logic [7:0]                   rsp_out_byte,
   output logic                         rsp_last
);
   import snte_pkg::*;

   logic                   cur_valid_ff, cur_valid_in;
   logic                   hdr_pend_ff, hdr_pend_in;
   logic [SNTE_GRP_W-1:0]  grp_ff, grp_in;
   logic [7:0]             hdr_ff, hdr_in;
   logic [SNTE_BODY_W-1:0] body_ff, body_in;
   logic [7:0]             tail_ff, tail_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_byte_ff, rsp_byte_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [SNTE_GRP_W-1:0]  grp_dec;
   logic                   finishing;

   assign grp_dec   = grp_ff - 1'b1;
   assign finishing = cur_valid_ff && !hdr_pend_ff && (grp_ff == '0);
   assign pop       = q_valid && (!cur_valid_ff || finishing);

   always_comb begin
      cur_valid_in = cur_valid_ff;
      hdr_pend_in  = hdr_pend_ff;
      grp_in       = grp_ff;
      hdr_in       = hdr_ff;
      body_in      = body_ff;
      tail_in      = tail_ff;
      rsp_valid_in = cur_valid_ff;
      rsp_byte_in  = tail_ff;
      rsp_last_in  = 1'b0;

      if (cur_valid_ff) begin
         if (hdr_pend_ff) begin
            rsp_byte_in = hdr_ff;
            hdr_pend_in = 1'b0;
         end else if (grp_ff != '0) begin
            rsp_byte_in = {1'b0, body_ff[grp_dec*SNTE_GRP_BITS +: SNTE_GRP_BITS]};
            grp_in      = grp_dec;
         end else begin
            rsp_byte_in  = tail_ff;
            rsp_last_in  = 1'b1;
            cur_valid_in = 1'b0;
         end
      end

      if (pop) begin
         cur_valid_in = 1'b1;
         hdr_pend_in  = q_desc.has_hdr;
         grp_in       = q_desc.ngrp;
         hdr_in       = q_desc.hdr;
         body_in      = q_desc.body;
         tail_in      = q_desc.tail;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         hdr_pend_ff  <= 1'b0;
         grp_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         hdr_pend_ff  <= hdr_pend_in;
         grp_ff       <= grp_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff      <= hdr_in;
      body_ff     <= body_in;
      tail_ff     <= tail_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

`ifndef SYNTHESIS
   a_token_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> cur_valid_ff)
      else $error("token bytes not contiguous");
   a_hdr_not_last: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff && hdr_pend_ff |=> rsp_valid_ff && !rsp_last_ff)
      else $error("header byte flagged last");
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff && !finishing |-> !pop)
      else $error("descriptor loaded over active token");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/smile_number_token_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smile_number_token_encoder
// Binary JSON number token encoder: zigzag varints and float bit groups.
// ----------------------------------------------------------------------------
//  channel  | handshake        | word
//  ---------+------------------+-------------------------------------------
//  request  | start / busy     | req_mode[1:0], req_value[63:0]
//  response | rsp_valid strobe | rsp_out_byte[7:0], rsp_last
//
//  One byte leaves per cycle while a token is being serialized; a token has
//  1 to 11 bytes. The first byte passes through the descriptor queue, the
//  serializer's token registers and the registered response outputs.
//  busy is high only while the descriptor queue is full; mode three is
//  taken and dropped without a response.
//  Synchronous active-high reset empties the queue and the serializer.
//  The receiver cannot stall; the response strobe lasts one cycle per byte.
// ----------------------------------------------------------------------------
module smile_number_token_encoder #(
   parameter int QueueDepth = snte_pkg::SNTE_QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_mode,
   input  wire logic [63:0] req_value,
   output logic             rsp_valid,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last
);
   import snte_pkg::*;

   snte_desc_type front_desc;
   snte_desc_type q_desc;
   logic          front_ok;
   logic          q_full;
   logic          q_valid;
   logic          q_pop;
   logic          q_push;

   // front end: classify the number combinationally at the request port
   snte_front u_front (
      .req_mode  (req_mode),
      .req_value (req_value),
      .desc      (front_desc),
      .desc_ok   (front_ok)
   );

   // accepted word with a meaningful mode goes into the queue
   assign busy   = q_full;
   assign q_push = start && !q_full && front_ok;

   snte_queue #(
      .DEPTH (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (front_desc),
      .full      (q_full),
      .q_valid   (q_valid),
      .q_desc    (q_desc),
      .pop       (q_pop)
   );

   // back end: one byte per cycle while a token is in progress; a queued next token follows without a gap
   snte_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_desc       (q_desc),
      .pop          (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the number token encoder: drives integer, float32,
// float64 and unused-mode words through the start/busy port, predicts each
// token's bytes and compares every strobed output byte against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
   import snte_pkg::*;

   // Selector value with no meaning: taken by the block, dropped, no bytes out
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int RANDOM_WORDS = 180;

   // One output byte of a token
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } token_byte_type;

   // Holds the bytes still owed by the block, oldest first, and checks each
   // strobed byte against the head of that list.
   class token_board;
      token_byte_type owed[$];
      int             fail_count;

      function new();
         fail_count = 0;
      endfunction

      function void push_byte(logic [7:0] code, logic is_last);
         token_byte_type b;
         b.out_byte = code;
         b.last     = is_last;
         owed.insert(owed.size(), b);
      endfunction

      // Varint body: 7-bit groups above the low six bits, only as many as
      // the nonzero part needs, then the end byte with its mark.
      function void push_varint(logic [63:0] k);
         logic [6:0]  grp [10];
         logic [63:0] rest;
         int          cnt;
         cnt  = 0;
         rest = k >> 6;
         while (rest != 64'd0 && cnt < 10) begin
            grp[cnt] = rest[6:0];
            cnt++;
            rest = rest >> 7;
         end
         for (int i = cnt - 1; i >= 0; i--) begin
            push_byte({1'b0, grp[i]}, 1'b0);
         end
         push_byte({SNTE_VAR_END, k[5:0]}, 1'b1);
      endfunction

      // Raw bit pattern as a fixed count of 7-bit groups, top group first
      function void push_groups(logic [63:0] bits, int count);
         logic [63:0] part;
         for (int i = count - 1; i >= 0; i--) begin
            part = bits >> (7 * i);
            push_byte({1'b0, part[6:0]}, i == 0);
         end
      endfunction

      // Expected token for one accepted word
      function void encode_number(logic [1:0] mode, logic [63:0] value);
         logic [63:0] mask;
         logic [63:0] zz64;
         logic [31:0] zz32;
         mask = {64{value[63]}};
         zz64 = (value << 1) ^ mask;
         case (mode)
            SNTE_MODE_INT: begin
               // -16..15 maps onto 0..31 after adding 16 (mod 2^64)
               if (value + 64'd16 < 64'd32) begin
                  push_byte(SNTE_SMALL_PFX | {3'b000, zz64[4:0]}, 1'b1);
               end else if (value + 64'h8000_0000 < 64'h1_0000_0000) begin
                  zz32 = (value[31:0] << 1) ^ mask[31:0];
                  push_byte(SNTE_HDR_INT32, 1'b0);
                  push_varint({32'd0, zz32});
               end else begin
                  push_byte(SNTE_HDR_INT64, 1'b0);
                  push_varint(zz64);
               end
            end
            SNTE_MODE_F32: begin
               push_byte(SNTE_HDR_F32, 1'b0);
               push_groups({32'd0, value[31:0]}, 5);
            end
            SNTE_MODE_F64: begin
               push_byte(SNTE_HDR_F64, 1'b0);
               push_groups(value, 10);
            end
            default: begin
            end
         endcase
      endfunction

      function void note_word(logic [1:0] mode, logic [63:0] value);
         encode_number(mode, value);
      endfunction

      function int pending();
         return owed.size();
      endfunction

      task report(string what);
         $display("[%0t] mismatch: %s", $time, what);
         fail_count++;
      endtask

      task check_word(logic [7:0] got_byte, logic got_last);
         token_byte_type want;
         if (owed.size() == 0) begin
            report($sformatf("unexpected byte %02h last=%0b", got_byte, got_last));
         end else begin
            want = owed.pop_front();
            if (got_byte !== want.out_byte) begin
               report($sformatf("out_byte %02h, expected %02h", got_byte, want.out_byte));
            end
            if (got_last !== want.last) begin
               report($sformatf("last %0b, expected %0b (byte %02h)",
                                got_last, want.last, want.out_byte));
            end
         end
      endtask
   endclass

   // ------------------------------------------------------------------------
   // Clock, reset and block inputs; every input is known from time zero
   // ------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [1:0]  req_mode = SNTE_MODE_INT;
   logic [63:0] req_value = 64'd0;
   logic        busy;
   logic        rsp_valid;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;

   token_board board = new();

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   smile_number_token_encoder DUT (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_mode     (req_mode),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

   // ------------------------------------------------------------------------
   // Output side: the receiver cannot stall, so every strobed byte is taken
   // at the edge that ends its cycle. Values read here are pre-edge values.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         board.check_word(rsp_out_byte, rsp_last);
      end
   end

   // ------------------------------------------------------------------------
   // Input side
   // ------------------------------------------------------------------------

   // Present one word and hold it until an edge sees start high, busy low.
   // Called at a rising edge; leaves start high so a following word can go
   // out back to back with a single assignment per step.
   task automatic drive_word(logic [1:0] mode, logic [63:0] value);
      start     <= 1'b1;
      req_mode  <= mode;
      req_value <= value;
      do begin
         @(posedge clock);
      end while (busy);
      board.note_word(mode, value);
   endtask

   // Idle burst: start low, junk on the word ports
   task automatic idle_burst(int cycles);
      start     <= 1'b0;
      req_mode  <= 2'($urandom);
      req_value <= {$urandom, $urandom};
      repeat (cycles) @(posedge clock);
   endtask

   // Random value spread over the three integer encodings and their edges
   function automatic logic [63:0] random_value();
      logic signed [63:0] wide;
      logic [31:0]        r32;
      logic [63:0]        base;
      r32  = $urandom;
      wide = {$urandom, $urandom};
      case ($urandom_range(0, 4))
         0: return 64'($urandom_range(0, 31)) - 64'd16;
         1: return {{32{r32[31]}}, r32};
         2: return wide;
         3: return wide >>> $urandom_range(0, 63);
         default: begin
            // around the short-form and 32-bit limits
            case ($urandom_range(0, 3))
               0: base = 64'd15;
               1: base = 64'hffff_ffff_ffff_fff0;
               2: base = 64'h0000_0000_7fff_ffff;
               default: base = 64'hffff_ffff_8000_0000;
            endcase
            return base + 64'($urandom_range(0, 2)) - 64'd1;
         end
      endcase
   endfunction

   initial begin : stimulus
      int          sent;
      int          pick;
      logic [1:0]  mode;
      logic [63:0] value;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // --- directed words ---
      // short form: both ends and just outside them
      drive_word(SNTE_MODE_INT, 64'd0);
      drive_word(SNTE_MODE_INT, 64'hffff_ffff_ffff_ffff);
      drive_word(SNTE_MODE_INT, 64'd15);
      drive_word(SNTE_MODE_INT, 64'hffff_ffff_ffff_fff0);
      drive_word(SNTE_MODE_INT, 64'd16);
      drive_word(SNTE_MODE_INT, 64'hffff_ffff_ffff_ffef);
      // 32-bit varint: one group appears once zigzag passes six bits
      drive_word(SNTE_MODE_INT, 64'd32);
      drive_word(SNTE_MODE_INT, 64'h0000_0000_7fff_ffff);
      drive_word(SNTE_MODE_INT, 64'hffff_ffff_8000_0000);
      // 64-bit varint: just past the 32-bit range, and the int64 ends
      drive_word(SNTE_MODE_INT, 64'h0000_0000_8000_0000);
      drive_word(SNTE_MODE_INT, 64'hffff_ffff_7fff_ffff);
      drive_word(SNTE_MODE_INT, 64'h7fff_ffff_ffff_ffff);
      drive_word(SNTE_MODE_INT, 64'h8000_0000_0000_0000);
      // float32: upper half ignored
      drive_word(SNTE_MODE_F32, 64'd0);
      drive_word(SNTE_MODE_F32, 64'hffff_ffff_ffff_ffff);
      drive_word(SNTE_MODE_F32, 64'hffff_ffff_0000_0000);
      drive_word(SNTE_MODE_F32, 64'h0000_0000_3f80_0000);
      // float64
      drive_word(SNTE_MODE_F64, 64'd0);
      drive_word(SNTE_MODE_F64, 64'hffff_ffff_ffff_ffff);
      drive_word(SNTE_MODE_F64, 64'haaaa_aaaa_5555_5555);
      // meaningless selector: swallowed, nothing out, then normal traffic
      drive_word(MODE_UNUSED, 64'hffff_ffff_ffff_ffff);
      drive_word(MODE_UNUSED, 64'd0);
      drive_word(SNTE_MODE_INT, 64'd1);
      idle_burst(5);

      // --- random words ---
      // Gaps come in alternate stretches of 35 words; the last 40 run flat out.
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         pick = $urandom_range(0, 15);
         if (pick == 0) begin
            mode = MODE_UNUSED;
         end else if (pick <= 8) begin
            mode = SNTE_MODE_INT;
         end else if (pick <= 11) begin
            mode = SNTE_MODE_F32;
         end else begin
            mode = SNTE_MODE_F64;
         end
         value = (mode == SNTE_MODE_INT) ? random_value() : {$urandom, $urandom};
         drive_word(mode, value);
         if (mode != MODE_UNUSED) begin
            sent++;
         end
         if (sent < RANDOM_WORDS - 40 && (sent / 35) % 2 == 0
             && $urandom_range(0, 2) == 0) begin
            idle_burst($urandom_range(1, 18));
         end
      end
      start <= 1'b0;

      // drain: wait until every owed byte has been checked, then idle with margin
      while (board.pending() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);

      if (board.fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run (~215 words)
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/snte_pkg.sv
hw/rtl/snte_front.sv
hw/rtl/snte_queue.sv
hw/rtl/snte_back.sv
hw/rtl/smile_number_token_encoder.sv
tb/tb.sv
